[src/s256iv_pkg.sv]
// ----------------------------------------------------------------------------
// s256iv_pkg
// types, round constants and sigma functions for the sha-256 hash block
// ----------------------------------------------------------------------------
`default_nettype none

package s256iv_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [0:7]  hash_t;
    typedef word_t [0:15] sched_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam logic [3:0]  NUM_IV     = 4'd8;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [5:0]  LAST_BYTE  = 6'd63;
    localparam logic [5:0]  LEN_START  = 6'd56;
    localparam logic [2:0]  LAST_WORD  = 3'd7;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    localparam hash_t STD_IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [0:NUM_ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

[src/s256iv_round.sv]
// ----------------------------------------------------------------------------
// s256iv_round
// one sha-256 round and one message schedule step, shared over all rounds
// ----------------------------------------------------------------------------
`default_nettype none

module s256iv_round
(
    input  wire  s256iv_pkg::hash_t  v,
    input  wire  s256iv_pkg::sched_t win,
    input  wire  s256iv_pkg::word_t  k,
    output var   s256iv_pkg::hash_t  v_out,
    output var   s256iv_pkg::word_t  w_new
);
    import s256iv_pkg::*;

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    assign t1    = v[7] + big_sig1(v[4]) + ch + k + win[0];
    assign t2    = big_sig0(v[0]) + maj;

    always_comb
    begin
        v_out[0] = t1 + t2;
        v_out[1] = v[0];
        v_out[2] = v[1];
        v_out[3] = v[2];
        v_out[4] = v[3] + t1;
        v_out[5] = v[4];
        v_out[6] = v[5];
        v_out[7] = v[6];
    end

    // w[t+16] from the window taps at t, t+1, t+9, t+14
    assign w_new = small_sig1(win[14]) + win[9] + small_sig0(win[1]) + win[0];

endmodule

`default_nettype wire

[src/sha256_custom_iv_hash.sv]
// ----------------------------------------------------------------------------
// sha256_custom_iv_hash
// sha-256 over a byte stream with a programmable initial hash value
// ----------------------------------------------------------------------------
//
//  channel  direction  beat
//  s_*      in         msg_byte in tdata, byte_present in tuser, end in tlast
//  m_*      out        digest_word in tdata, word_index in tuser, final in tlast
//  cfg_*    in         iv register write, index 0..7, others ignored
//
//  a byte beat is taken whenever s_tready is high; a full 64-byte block then goes
//  to the shared round unit (64 rounds, one fold into the chaining value)
//  an end beat starts padding at one byte a cycle, paused while a block compresses
//  (up to 72 bytes, one or two block compressions), then eight digest beats at the output
//  s_tready is low while compressing, padding or holding the digest
//  reset is asynchronous and loads the standard iv; no clearing pass
//
`default_nettype none

module sha256_custom_iv_hash
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,     // msg_byte
    input  wire  [0:0]  s_tuser,     // byte_present
    input  wire         s_tlast,     // end_of_message
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,     // digest_word
    output logic [2:0]  m_tuser,     // word_index
    output logic        m_tlast,     // final_word
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [3:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    import s256iv_pkg::*;

    state_t      state_reg,     state_next;
    hash_t       iv_reg,        iv_next;
    hash_t       chain_reg,     chain_next;
    hash_t       v_reg,         v_next;
    sched_t      win_reg,       win_next;
    logic [23:0] acc_reg,       acc_next;
    logic [5:0]  fill_reg,      fill_next;
    logic [60:0] bytes_reg,     bytes_next;
    logic        in_msg_reg,    in_msg_next;
    logic        pad_mode_reg,  pad_mode_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_wrap_reg,  pad_wrap_next;
    logic        final_reg,     final_next;
    logic [5:0]  round_reg,     round_next;
    logic [2:0]  out_idx_reg,   out_idx_next;

    logic        s_accept;
    logic        m_accept;
    logic        ins_en;
    logic [7:0]  ins_byte;
    logic        blk_done;
    logic        pad_is_len;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    hash_t       v_round;
    word_t       w_new;

    s256iv_round u_round
    (
        .v     (v_reg),
        .win   (win_reg),
        .k     (ROUND_K[round_reg]),
        .v_out (v_round),
        .w_new (w_new)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_accept  = m_tvalid && m_tready;
    assign m_tdata   = chain_reg[out_idx_reg];
    assign m_tuser   = out_idx_reg;
    assign m_tlast   = (out_idx_reg == LAST_WORD);

    // big-endian bit length, byte 56 of the block is the top byte
    assign len_bits   = {bytes_reg, 3'b000};
    assign len_byte   = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
    assign pad_is_len = !pad_first_reg && (fill_reg >= LEN_START) && !pad_wrap_reg;
    assign pad_byte   = pad_first_reg ? PAD_BYTE : (pad_is_len ? len_byte : 8'h00);

    assign ins_en   = (state_reg == ST_PAD) ||
                      ((state_reg == ST_IDLE) && s_accept && s_tuser[0]);
    assign ins_byte = (state_reg == ST_PAD) ? pad_byte : s_tdata;
    assign blk_done = ins_en && (fill_reg == LAST_BYTE);

    always_comb
    begin
        state_next     = state_reg;
        iv_next        = iv_reg;
        chain_next     = chain_reg;
        v_next         = v_reg;
        win_next       = win_reg;
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        bytes_next     = bytes_reg;
        in_msg_next    = in_msg_reg;
        pad_mode_next  = pad_mode_reg;
        pad_first_next = pad_first_reg;
        pad_wrap_next  = pad_wrap_reg;
        final_next     = final_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;

        if (cfg_valid && (cfg_index < NUM_IV))
        begin
            iv_next[cfg_index[2:0]] = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (!in_msg_reg && (s_tuser[0] || s_tlast))
                    begin
                        chain_next  = iv_reg;
                        in_msg_next = 1'b1;
                    end
                    if (s_tuser[0])
                    begin
                        bytes_next = bytes_reg + 61'd1;
                    end
                    if (s_tlast)
                    begin
                        pad_mode_next  = 1'b1;
                        pad_first_next = 1'b1;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                v_next = v_round;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = w_new;
                round_next   = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                pad_wrap_next = 1'b0;
                if (final_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end
                else if (pad_mode_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    pad_wrap_next = (fill_reg >= LEN_START);
                end
                if (pad_is_len && (fill_reg == LAST_BYTE))
                begin
                    final_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_accept)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD)
                    begin
                        state_next    = ST_IDLE;
                        in_msg_next   = 1'b0;
                        pad_mode_next = 1'b0;
                        final_next    = 1'b0;
                        bytes_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // byte path into the schedule window, four bytes make a word
        if (ins_en)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = {acc_reg, ins_byte};
            end
            else
            begin
                acc_next = {acc_reg[15:0], ins_byte};
            end
        end

        if (blk_done)
        begin
            v_next     = chain_reg;
            round_next = '0;
            state_next = ST_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iv_reg        <= STD_IV;
            fill_reg      <= '0;
            bytes_reg     <= '0;
            in_msg_reg    <= 1'b0;
            pad_mode_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_wrap_reg  <= 1'b0;
            final_reg     <= 1'b0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iv_reg        <= iv_next;
            fill_reg      <= fill_next;
            bytes_reg     <= bytes_next;
            in_msg_reg    <= in_msg_next;
            pad_mode_reg  <= pad_mode_next;
            pad_first_reg <= pad_first_next;
            pad_wrap_reg  <= pad_wrap_next;
            final_reg     <= final_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        v_reg     <= v_next;
        win_reg   <= win_next;
        acc_reg   <= acc_next;
    end

endmodule

`default_nettype wire

[test/sha256_custom_iv_hash_tb.sv]
// ----------------------------------------------------------------------------
// sha256_custom_iv_hash_tb
// self-checking bench for the sha-256 hash block with programmable iv
// ----------------------------------------------------------------------------
// Message bytes go in as stream beats from a queue that is filled phase by
// phase. Each phase first programs the eight iv registers: all zero, all
// ones, random values mixed with writes to unused indexes, and the standard
// iv. An in-bench sha-256 model follows every accepted input beat and every
// register write, and it queues the eight digest words that each ended
// message should give. The output monitor checks every digest beat against
// that queue. The sender runs in random bursts and the receiver stalls in
// changing patterns. One long receiver hold-off makes the block back up and
// stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_custom_iv_hash_tb;

    import s256iv_pkg::*;

    localparam int unsigned CLK_HALF       = 4;
    localparam int unsigned RESET_CYCLES   = 4;
    localparam int unsigned SETTLE_CYCLES  = 160;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS    = 84;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned NUM_PHASES     = 5;

    localparam logic [3:0] CFG_IV_FIRST  = 4'd0;
    localparam logic [3:0] CFG_IV_LAST   = 4'd7;
    localparam logic [3:0] CFG_INDEX_TOP = 4'd15;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int unsigned LEN_FIELD = 56;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam logic [2:0] TOP_WORD   = 3'd7;

    localparam hash_t SHA256_IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t SHA256_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int unsigned EDGE_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    typedef struct packed
    {
        logic [7:0] data;
        logic       present;
        logic       last;
    } msg_item_t;

    typedef struct packed
    {
        word_t      word;
        logic [2:0] index;
        logic       is_last;
    } digest_beat_t;

    typedef enum
    {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_THIRD,
        RX_SPARSE
    } rx_mode_t;

    typedef enum
    {
        IV_ZERO,
        IV_ONES,
        IV_RANDOM,
        IV_STANDARD
    } iv_setting_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata    = '0;     // msg_byte
    logic [0:0]  s_tuser    = '0;     // byte_present
    logic        s_tlast    = 1'b0;   // end_of_message
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [31:0] m_tdata;             // digest_word
    logic [2:0]  m_tuser;             // word_index
    logic        m_tlast;             // final_word
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index  = '0;
    logic [31:0] cfg_data   = '0;

    msg_item_t    item_q [$];
    digest_beat_t digest_q [$];

    // in-bench hash state
    hash_t       iv_shadow  = SHA256_IV;
    hash_t       chain_hash = SHA256_IV;
    sched_t      block_words = '0;
    int unsigned fill_bytes = 0;
    logic [60:0] msg_len    = '0;
    logic        msg_open   = 1'b0;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    int unsigned rx_tick    = 0;
    rx_mode_t    rx_mode    = RX_OPEN;

    int unsigned error_count   = 0;
    int unsigned words_checked = 0;
    int unsigned msgs_checked  = 0;
    int unsigned payload_beats = 0;
    int unsigned idle_beats    = 0;
    int unsigned longest_msg   = 0;
    int unsigned iv_settings   = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned queued_items  = 0;

    iv_setting_t phase_plan [NUM_PHASES] = '{IV_ZERO, IV_ONES, IV_RANDOM, IV_RANDOM,
                                             IV_STANDARD};

    sha256_custom_iv_hash DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic hash_t compress_block(input hash_t h, input sched_t blk);
        word_t w [64];
        word_t a, b, c, d, e, f, g, k, t1, t2;
        hash_t r;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = blk[t];
        end
        for (int t = 16; t < 64; t++)
        begin
            w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; k = h[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = k + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + SHA256_K[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            k = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        r[0] = h[0] + a; r[1] = h[1] + b; r[2] = h[2] + c; r[3] = h[3] + d;
        r[4] = h[4] + e; r[5] = h[5] + f; r[6] = h[6] + g; r[7] = h[7] + k;
        return r;
    endfunction

    task automatic open_message();
        if (!msg_open)
        begin
            chain_hash = iv_shadow;
            fill_bytes = 0;
            msg_len    = '0;
            msg_open   = 1'b1;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int unsigned wi;
        int unsigned sh;
        wi = fill_bytes >> 2;
        sh = 24 - 8 * (fill_bytes & 3);
        block_words[wi][sh +: 8] = b;
        fill_bytes++;
        if (fill_bytes == BLOCK_BYTES)
        begin
            chain_hash = compress_block(chain_hash, block_words);
            fill_bytes = 0;
        end
    endtask

    task automatic hash_beat(input msg_item_t it);
        logic [63:0] bit_len;
        if (it.present)
        begin
            open_message();
            absorb_byte(it.data);
            msg_len = msg_len + 61'd1;
            if (msg_len > longest_msg)
                longest_msg = 32'(msg_len);
        end
        if (it.last)
        begin
            open_message();
            bit_len = {msg_len, 3'b000};
            absorb_byte(PAD_MARK);
            if (fill_bytes > LEN_FIELD)
            begin
                while (fill_bytes != 0)
                    absorb_byte(8'h00);
            end
            while (fill_bytes < LEN_FIELD)
                absorb_byte(8'h00);
            block_words[14] = bit_len[63:32];
            block_words[15] = bit_len[31:0];
            chain_hash = compress_block(chain_hash, block_words);
            for (int i = 0; i < 8; i++)
            begin
                digest_q.push_back('{chain_hash[i], 3'(i), 3'(i) == TOP_WORD});
            end
            chain_hash = iv_shadow;
            fill_bytes = 0;
            msg_len    = '0;
            msg_open   = 1'b0;
        end
    endtask

    // expected digests follow accepted beats and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready && cfg_index <= CFG_IV_LAST)
                iv_shadow[cfg_index[2:0]] = cfg_data;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] || s_tlast)
                    payload_beats++;
                else
                    idle_beats++;
                hash_beat('{s_tdata, s_tuser[0], s_tlast});
            end
        end
    end

    // input driver, bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_input
        msg_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (item_q.size() != 0)
            begin
                nxt = item_q.pop_front();
                s_tvalid   <= 1'b1;
                s_tdata    <= nxt.data;
                s_tuser[0] <= nxt.present;
                s_tlast    <= nxt.last;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    if ($urandom_range(0, 3) == 0)
                        gap_left <= $urandom_range(4, 20);
                    else
                        gap_left <= $urandom_range(0, 2);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, switches between random stall patterns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            else
            begin
                mode_left--;
            end
            rx_tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:        m_tready <= 1'b1;
                    RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY_THIRD: m_tready <= (rx_tick % 3 == 0);
                    default:        m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // digest checker
    always @(posedge clk)
    begin : check_digest
        digest_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
            begin
                flag_error($sformatf("unexpected digest beat %h idx %0d last %b",
                                     m_tdata, m_tuser, m_tlast));
            end
            else
            begin
                want = digest_q.pop_front();
                words_checked++;
                if (want.is_last)
                    msgs_checked++;
                if (m_tdata !== want.word || m_tuser !== want.index
                    || m_tlast !== want.is_last)
                    flag_error($sformatf({"digest mismatch: expected %h idx %0d last %b,",
                                          " got %h idx %0d last %b"},
                                         want.word, want.index, want.is_last,
                                         m_tdata, m_tuser, m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d digest words pending",
                         quiet_cycles, digest_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [7:0] data, input logic present, input logic last);
        item_q.push_back('{data, present, last});
        if (present || last)
            queued_items++;
    endtask

    task automatic queue_message(input int unsigned len);
        logic end_on_byte;
        end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic write_cfg(input logic [3:0] idx, input word_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_iv(input iv_setting_t setting);
        word_t val;
        for (int i = CFG_IV_FIRST; i <= CFG_IV_LAST; i++)
        begin
            case (setting)
                IV_ZERO:     val = '0;
                IV_ONES:     val = '1;
                IV_STANDARD: val = SHA256_IV[i];
                default:     val = $urandom;
            endcase
            write_cfg(4'(i), val);
        end
        // writes past the last iv register must leave the ivs alone
        if (setting == IV_RANDOM)
        begin
            for (int j = 0; j < 3; j++)
                write_cfg(4'($urandom_range(CFG_IV_LAST + 1, CFG_INDEX_TOP)), $urandom);
        end
        iv_settings++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (item_q.size() != 0 || s_tvalid || digest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned target;
        int unsigned len;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        iv_settings = 1;

        // directed: empty message, idle beats, short messages, byte extremes
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h7f, 1'b1, 1'b0);
        push_item(8'h55, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hff, 1'b1, 1'b1);
        push_item(8'haa, 1'b0, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_iv(phase_plan[p]);
            if (p == 2)
                hold_request = 1'b1;
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = EDGE_LEN[$urandom_range(0, 7)];
                else
                    len = $urandom_range(0, 24);
                queue_message(len);
            end
            wait_drained();
        end

        $display("covered %0d messages and %0d digest words from %0d data/end beats",
                 msgs_checked, words_checked, payload_beats);
        $display("plus %0d idle beats under %0d iv settings, longest message %0d bytes",
                 idle_beats, iv_settings, longest_msg);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
